>>> rtl/tmwe_pkg.sv
package tmwe_pkg;

   localparam int MaxTasks   = 16;
   localparam int QueueDepth = 8;
   localparam int TaskW      = $clog2(MaxTasks);
   localparam int SlotW      = $clog2(QueueDepth);
   localparam int CountW     = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      CMD_PUT     = 3'd0,
      CMD_GET     = 3'd1,
      CMD_WAIT    = 3'd2,
      CMD_SUSPEND = 3'd3,
      CMD_RELEASE = 3'd4,
      CMD_FLUSH   = 3'd5,
      CMD_TICK    = 3'd6,
      CMD_NONE    = 3'd7
   } cmd_type;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOTASK     = 3'd1;
   localparam logic [2:0] ST_NOTAWAITED = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_EMPTY      = 3'd4;
   localparam logic [2:0] ST_NOTSUSP    = 3'd5;
   localparam logic [2:0] ST_WAITING    = 3'd6;

   localparam logic [1:0] REG_MSEC   = 2'd0;
   localparam logic [1:0] REG_ACTIVE = 2'd1;
   localparam logic [1:0] REG_QSIZE  = 2'd2;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [4:0]         task_id;
      logic signed [15:0] msg_type;
      logic               match_any;
      logic [15:0]        word_data;
      logic [31:0]        dword_data;
      logic [15:0]        time_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] type_out;
      logic [15:0]        word_out;
      logic [31:0]        dword_out;
      logic [15:0]        woken_mask;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_PUT, S_POP_RD, S_POP_CHK, S_DIV, S_SUSP,
      S_TICK, S_DONE, S_OUT
   } state_type;

   typedef struct packed {
      logic load;      // latch request, compute task index
      logic do_put;    // put decision and store write
      logic pop_rd;    // issue message read at head
      logic pop_chk;   // consume popped message
      logic div_start;
      logic div_step;
      logic susp;      // write deadline and suspend state
      logic simple;    // get empty/release/flush bookkeeping
      logic tick_start;
      logic tick_step;
      logic emit;
   } ctl_type;

   typedef struct packed {
      logic       bad_task;
      logic [2:0] cmd;
      logic       ring_empty;
      logic       pop_match;
      logic       div_done;
      logic       tick_done;
   } sts_type;

endpackage

>>> rtl/task_mailbox_and_wakeup_engine.sv
// One result beat per command beat, one command at a time. Release, flush, a get
// on an empty ring, a bad id or an unknown command go straight to the result; put
// adds a store step, and a get reads and checks the head message. Wait drains
// messages until one matches and suspends through the serial divider if none does;
// suspend also goes through the divider, and tick scans every active task in turn.
// Synchronous active-high reset restores register defaults and clears all task state;
// message storage is not cleared.
module task_mailbox_and_wakeup_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tmwe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmwe_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import tmwe_pkg::*;

   ctl_type ctl;
   sts_type sts;
   rsp_type res;
   logic    busy;
   logic    rv_ff;
   rsp_type rd_ff;

   assign req_stall = busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   tmwe_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_go(req_valid && !busy),
      .out_free(!rv_ff || !rsp_stall), .sts(sts), .ctl(ctl), .busy(busy)
   );

   tmwe_dp u_dp (
      .clock(clock), .reset(reset), .req_data(req_data),
      .csr_we(csr_valid), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .ctl(ctl), .sts(sts), .rsp_result(res)
   );

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (ctl.emit) rv_ff <= 1'b1;
      else if (!rsp_stall) rv_ff <= 1'b0;
      if (ctl.emit) rd_ff <= res;
   end

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (!rv_ff || !rsp_stall)) else $error("result overwritten");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> busy) else $error("no busy after accept");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rd_ff.status != 3'd7) else $error("bad status");
endmodule

>>> rtl/tmwe_ctrl.sv
module tmwe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_go,
   input  logic              out_free,
   input  tmwe_pkg::sts_type sts,
   output tmwe_pkg::ctl_type ctl,
   output logic              busy
);
   import tmwe_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_go) state_in = S_DECODE;
         S_DECODE: begin
            if (sts.cmd == CMD_TICK) state_in = S_TICK;
            else if (sts.cmd == CMD_NONE || sts.bad_task) state_in = S_DONE;
            else begin
               case (sts.cmd)
                  CMD_PUT:     state_in = S_PUT;
                  CMD_GET:     state_in = sts.ring_empty ? S_DONE : S_POP_RD;
                  CMD_WAIT:    state_in = sts.ring_empty ? S_DIV : S_POP_RD;
                  CMD_SUSPEND: state_in = S_DIV;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_PUT:     state_in = S_DONE;
         S_POP_RD:  state_in = S_POP_CHK;
         S_POP_CHK: begin
            if (sts.cmd == CMD_GET || sts.pop_match) state_in = S_DONE;
            else if (sts.ring_empty) state_in = S_DIV;
            else state_in = S_POP_RD;
         end
         S_DIV:  if (sts.div_done) state_in = S_SUSP;
         S_SUSP: state_in = S_DONE;
         S_TICK: if (sts.tick_done) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      busy = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE:   ctl.load = req_go;
         S_DECODE: begin
            ctl.simple     = !sts.bad_task && sts.cmd != CMD_TICK;
            ctl.tick_start = sts.cmd == CMD_TICK;
            ctl.div_start  = !sts.bad_task && (sts.cmd == CMD_SUSPEND ||
                             (sts.cmd == CMD_WAIT && sts.ring_empty));
         end
         S_PUT:     ctl.do_put = 1'b1;
         S_POP_RD:  ctl.pop_rd = 1'b1;
         S_POP_CHK: begin
            ctl.pop_chk   = 1'b1;
            ctl.div_start = sts.cmd == CMD_WAIT && !sts.pop_match && sts.ring_empty;
         end
         S_DIV:  ctl.div_step = 1'b1;
         S_SUSP: ctl.susp = 1'b1;
         S_TICK: ctl.tick_step = 1'b1;
         S_DONE: ctl.emit = out_free;
         default: ;
      endcase
   end
endmodule

>>> rtl/tmwe_dp.sv
module tmwe_dp (
   input  logic              clock,
   input  logic              reset,
   input  tmwe_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   input  tmwe_pkg::ctl_type ctl,
   output tmwe_pkg::sts_type sts,
   output tmwe_pkg::rsp_type rsp_result
);
   import tmwe_pkg::*;

   logic [15:0] msec_ff;
   logic [4:0]  active_ff;
   logic [3:0]  qsize_ff;

   logic [MaxTasks-1:0] susp_ff, waitm_ff, any_ff;
   logic [31:0]         dl_ff   [MaxTasks];
   logic [15:0]         atype_ff[MaxTasks];
   logic [SlotW-1:0]    head_ff [MaxTasks];
   logic [SlotW-1:0]    tail_ff [MaxTasks];
   logic [CountW-1:0]   cnt_ff  [MaxTasks];
   logic [31:0]         tick_ff;
   logic [63:0]         mem [MaxTasks*QueueDepth];
   logic [63:0]         rd_ff;

   req_type          rq_ff;
   logic [TaskW-1:0] t_ff;
   logic             bad_ff;
   rsp_type          res_ff;

   // Divider: 16-bit restoring, one quotient bit per cycle.
   logic [15:0] quo_ff, rem_ff, dvs_ff;
   logic [4:0]  dcnt_ff;
   logic [TaskW:0] scan_ff;

   logic [4:0]  eff_active;
   logic [CountW-1:0] eff_q;
   logic [4:0]  tid;
   logic [TaskW-1:0] t;
   logic [SlotW-1:0] hd, tl;
   logic [16:0] rtrial;
   logic [15:0] rshift;
   logic [31:0] dticks;
   logic [31:0] nticks;
   logic        wake_ok;
   logic [TaskW-1:0] si;
   logic [2:0]  ld_status;

   assign eff_active = (active_ff > 5'(MaxTasks)) ? 5'(MaxTasks) : active_ff;
   assign eff_q = (qsize_ff == 4'd0) ? CountW'(1) :
                  (qsize_ff > 4'(QueueDepth)) ? CountW'(QueueDepth) : CountW'(qsize_ff);
   assign t  = t_ff;
   assign hd = head_ff[t];
   assign tl = tail_ff[t];
   assign si = scan_ff[TaskW-1:0];

   function automatic logic [SlotW-1:0] nxt(input logic [SlotW-1:0] i,
                                            input logic [CountW-1:0] q);
      logic [CountW-1:0] n;
      n = CountW'(i) + CountW'(1);
      return (n >= q) ? '0 : SlotW'(n);
   endfunction

   assign sts.bad_task   = bad_ff;
   assign sts.cmd        = rq_ff.cmd;
   assign sts.ring_empty = (cnt_ff[t] == '0);
   assign sts.pop_match  = rq_ff.match_any || (rd_ff[15:0] == rq_ff.msg_type);
   assign sts.div_done   = (dcnt_ff == 5'd0);
   assign sts.tick_done  = (scan_ff >= (TaskW+1)'(eff_active));
   assign rsp_result     = res_ff;

   assign rshift = {rem_ff[14:0], quo_ff[15]};
   assign rtrial = {rem_ff, quo_ff[15]} - {1'b0, dvs_ff};
   assign dticks = (quo_ff == 16'd0) ? 32'd1 : {16'd0, quo_ff};
   assign nticks = tick_ff + 32'd1;
   assign wake_ok = susp_ff[si] && dl_ff[si] != 32'd0 && tick_ff >= dl_ff[si];
   assign tid = req_data.task_id;
   assign ld_status = ((tid == 5'd0 || tid > eff_active) &&
                       req_data.cmd != CMD_TICK && req_data.cmd != CMD_NONE) ?
                      ST_NOTASK : ST_OK;

   always_ff @(posedge clock) begin
      if (ctl.pop_rd) rd_ff <= mem[{t, hd}];
      if (ctl.do_put && cnt_ff[t] < eff_q &&
          !(susp_ff[t] && waitm_ff[t] && !any_ff[t] &&
            atype_ff[t] != rq_ff.msg_type))
         mem[{t, tl}] <= {rq_ff.dword_data, rq_ff.word_data, rq_ff.msg_type};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msec_ff <= 16'd10; active_ff <= 5'd1; qsize_ff <= 4'd8;
         susp_ff <= '0; waitm_ff <= '0; any_ff <= '1; tick_ff <= '0;
         for (int i = 0; i < MaxTasks; i++) begin
            dl_ff[i] <= '0; atype_ff[i] <= '0;
            head_ff[i] <= '0; tail_ff[i] <= '0; cnt_ff[i] <= '0;
         end
         scan_ff <= '0; dcnt_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MSEC:   msec_ff   <= csr_wdata[15:0];
               REG_ACTIVE: active_ff <= csr_wdata[4:0];
               REG_QSIZE:  qsize_ff  <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (ctl.load) begin
            rq_ff  <= req_data;
            bad_ff <= (tid == 5'd0) || (tid > eff_active);
            t_ff   <= TaskW'(tid - 5'd1);
            res_ff <= '{status: ld_status, default: 0};
         end
         if (ctl.simple) begin
            case (rq_ff.cmd)
               CMD_GET: if (cnt_ff[t] == '0) res_ff.status <= ST_EMPTY;
               CMD_RELEASE: begin
                  if (susp_ff[t]) begin
                     susp_ff[t] <= 1'b0; waitm_ff[t] <= 1'b0; any_ff[t] <= 1'b1;
                  end else res_ff.status <= ST_NOTSUSP;
               end
               CMD_FLUSH: begin
                  head_ff[t] <= '0; tail_ff[t] <= '0; cnt_ff[t] <= '0;
               end
               default: ;
            endcase
         end
         if (ctl.do_put) begin
            if (susp_ff[t] && waitm_ff[t] && !any_ff[t] &&
                atype_ff[t] != rq_ff.msg_type) begin
               res_ff.status <= ST_NOTAWAITED;
            end else begin
               if (susp_ff[t] && waitm_ff[t]) begin
                  susp_ff[t] <= 1'b0; waitm_ff[t] <= 1'b0; any_ff[t] <= 1'b1;
                  dl_ff[t] <= '0;
               end
               if (cnt_ff[t] < eff_q) begin
                  tail_ff[t] <= nxt(tl, eff_q);
                  cnt_ff[t]  <= cnt_ff[t] + CountW'(1);
               end else res_ff.status <= ST_FULL;
            end
         end
         if (ctl.pop_rd) begin
            head_ff[t] <= nxt(hd, eff_q);
            cnt_ff[t]  <= cnt_ff[t] - CountW'(1);
         end
         if (ctl.pop_chk && (rq_ff.cmd == CMD_GET || sts.pop_match)) begin
            res_ff.type_out  <= rd_ff[15:0];
            res_ff.word_out  <= rd_ff[31:16];
            res_ff.dword_out <= rd_ff[63:32];
         end
         if (ctl.div_start) begin
            quo_ff  <= rq_ff.time_ms;
            rem_ff  <= '0;
            dvs_ff  <= (msec_ff == 16'd0) ? 16'd1 : msec_ff;
            dcnt_ff <= 5'd16;
         end else if (ctl.div_step && dcnt_ff != 5'd0) begin
            dcnt_ff <= dcnt_ff - 5'd1;
            if (!rtrial[16]) begin
               rem_ff <= rtrial[15:0];
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rshift;
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
         end
         if (ctl.susp) begin
            susp_ff[t] <= 1'b1;
            dl_ff[t]   <= (rq_ff.time_ms == 16'd0) ? 32'd0 : dticks + tick_ff;
            if (rq_ff.cmd == CMD_WAIT) begin
               waitm_ff[t] <= 1'b1;
               any_ff[t]   <= rq_ff.match_any;
               atype_ff[t] <= rq_ff.msg_type;
               res_ff.status <= ST_WAITING;
            end
         end
         if (ctl.tick_start) begin
            tick_ff <= nticks;
            scan_ff <= '0;
         end else if (ctl.tick_step && !sts.tick_done) begin
            scan_ff <= scan_ff + (TaskW+1)'(1);
            if (wake_ok) begin
               susp_ff[si] <= 1'b0; waitm_ff[si] <= 1'b0; any_ff[si] <= 1'b1;
               res_ff.woken_mask[si] <= 1'b1;
            end
         end
      end
   end
endmodule
